// ===== rtl/core/slso_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted-list set operations: shared package
// Types, codes and default sizes for the set operation unit and its RAMs.
// ---------------------------------------------------------------------------
package slso_pkg;

    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 16;

    // set_op register codes
    typedef enum logic [1:0] {
        OP_MERGE     = 2'd0,
        OP_UNION     = 2'd1,
        OP_INTERSECT = 2'd2,
        OP_DIFF      = 2'd3
    } t_set_op;

    // input item mode codes; the fourth code is ignored
    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

endpackage

// ===== rtl/core/slso_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ---------------------------------------------------------------------------
module slso_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sorted_list_set_operations_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted-list set operations unit
// Loads two ascending lists of signed values and streams their merge, union,
// intersection or difference on a run item.
// ---------------------------------------------------------------------------
// A load item (mode 0 for list A, mode 1 for list B) appends its value to
// that list; a load into a list already holding DEPTH values is dropped. A
// run item (mode 2) walks both lists with two pointers, one comparison step
// per cycle while the output is not stalled, and emits one result per step
// that produces an element, then clears both lists; mode 3 is taken and
// ignored. The run holds the input stall high until the walk is done, with
// at most count_a + count_b steps, and longer while the output is stalled:
// each list sits in its own RAM with a registered read, and the read address
// is the pointer's next value, so the heads are ready every cycle. Results
// pass through a one-deep pending register so that the final element can be
// marked last; a run with no elements gives a single item flagged empty and
// last with value zero. Equal heads: merge takes B first, union emits B once
// and advances both, intersection emits A and advances A only, difference
// drops both. set_op is written through the configuration channel, which is
// always ready; write it only while no run is in flight.
// ---------------------------------------------------------------------------
module sorted_list_set_operations_unit #(
    parameter  int DEPTH = slso_pkg::DEFAULT_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_mode,
    input  logic signed [slso_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [slso_pkg::DATA_W-1:0] o_result_value,
    output logic                               o_result_empty,
    output logic                               o_result_last,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_set_op
);

    import slso_pkg::*;

    // control state
    t_state          r_state, n_state;
    t_set_op         r_set_op;
    logic [CW-1:0]   r_cnt_a, n_cnt_a;
    logic [CW-1:0]   r_cnt_b, n_cnt_b;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic            r_pvalid, n_pvalid;
    logic            r_ovalid, n_ovalid;

    // payload
    logic [DATA_W-1:0] r_pval, n_pval;
    logic [DATA_W-1:0] r_oval, n_oval;
    logic              r_oempty, n_oempty;
    logic              r_olast, n_olast;

    // RAM side
    logic              we_a, we_b;
    logic [DATA_W-1:0] q_a, q_b;

    // walk decision
    logic              in_xfer;
    logic              can_emit;
    logic              a_has, b_has;
    logic              a_lt, a_gt;
    logic              step_emit, step_inc_i, step_inc_j, walk_done;
    logic [DATA_W-1:0] step_val;

    assign in_xfer  = i_valid && !o_stall;
    assign can_emit = !r_ovalid || !i_stall;
    assign a_has    = r_i < r_cnt_a;
    assign b_has    = r_j < r_cnt_b;
    assign a_lt     = $signed(q_a) < $signed(q_b);
    assign a_gt     = $signed(q_b) < $signed(q_a);

    // One comparison step on the current heads.
    always_comb begin
        step_emit  = 1'b0;
        step_inc_i = 1'b0;
        step_inc_j = 1'b0;
        walk_done  = 1'b0;
        step_val   = q_a;
        priority if (a_has && b_has) begin
            unique case (r_set_op)
                OP_MERGE: begin
                    step_emit = 1'b1;
                    if (a_lt) begin
                        step_inc_i = 1'b1;
                    end else begin
                        step_val   = q_b;
                        step_inc_j = 1'b1;
                    end
                end
                OP_UNION: begin
                    step_emit = 1'b1;
                    if (a_lt) begin
                        step_inc_i = 1'b1;
                    end else if (a_gt) begin
                        step_val   = q_b;
                        step_inc_j = 1'b1;
                    end else begin
                        step_val   = q_b;
                        step_inc_i = 1'b1;
                        step_inc_j = 1'b1;
                    end
                end
                OP_INTERSECT: begin
                    if (a_lt) begin
                        step_inc_i = 1'b1;
                    end else if (a_gt) begin
                        step_inc_j = 1'b1;
                    end else begin
                        step_emit  = 1'b1;
                        step_inc_i = 1'b1;
                    end
                end
                OP_DIFF: begin
                    if (a_lt) begin
                        step_emit  = 1'b1;
                        step_inc_i = 1'b1;
                    end else if (a_gt) begin
                        step_inc_j = 1'b1;
                    end else begin
                        step_inc_i = 1'b1;
                        step_inc_j = 1'b1;
                    end
                end
                default: begin
                    walk_done = 1'b1;
                end
            endcase
        end else if (a_has && r_set_op != OP_INTERSECT) begin
            // drain the rest of A
            step_emit  = 1'b1;
            step_inc_i = 1'b1;
        end else if (b_has && (r_set_op == OP_MERGE || r_set_op == OP_UNION)) begin
            // drain the rest of B
            step_emit  = 1'b1;
            step_val   = q_b;
            step_inc_j = 1'b1;
        end else begin
            walk_done = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && t_mode'(i_mode) == MODE_RUN) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (can_emit && walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output updates.
    always_comb begin
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_i      = r_i;
        n_j      = r_j;
        n_pvalid = r_pvalid;
        n_pval   = r_pval;
        n_ovalid = r_ovalid && i_stall;
        n_oval   = r_oval;
        n_oempty = r_oempty;
        n_olast  = r_olast;
        we_a     = 1'b0;
        we_b     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (i_mode)
                        MODE_LOAD_A: begin
                            if (r_cnt_a < CW'(DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                        end
                        MODE_LOAD_B: begin
                            if (r_cnt_b < CW'(DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (can_emit) begin
                    if (walk_done) begin
                        // flush the pending element as last, or report empty
                        n_ovalid = 1'b1;
                        n_olast  = 1'b1;
                        n_oempty = !r_pvalid;
                        n_oval   = r_pvalid ? r_pval : '0;
                        n_pvalid = 1'b0;
                        n_cnt_a  = '0;
                        n_cnt_b  = '0;
                        n_i      = '0;
                        n_j      = '0;
                    end else begin
                        n_i = step_inc_i ? r_i + CW'(1) : r_i;
                        n_j = step_inc_j ? r_j + CW'(1) : r_j;
                        if (step_emit) begin
                            if (r_pvalid) begin
                                n_ovalid = 1'b1;
                                n_olast  = 1'b0;
                                n_oempty = 1'b0;
                                n_oval   = r_pval;
                            end
                            n_pvalid = 1'b1;
                            n_pval   = step_val;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_set_op <= OP_MERGE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_i      <= n_i;
            r_j      <= n_j;
            r_pvalid <= n_pvalid;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_set_op <= t_set_op'(i_cfg_set_op);
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_pval   <= n_pval;
        r_oval   <= n_oval;
        r_oempty <= n_oempty;
        r_olast  <= n_olast;
    end

    // Read at the pointers' next value so the heads land in step with them.
    slso_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (q_a)
    );

    slso_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (q_b)
    );

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_result_empty = r_oempty;
    assign o_result_last  = r_olast;
    assign o_cfg_ready    = 1'b1;

    // Pointers never run past the filled part of their list.
    a_ptr_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= r_cnt_a && r_j <= r_cnt_b)
        else $error("walk pointer beyond list fill");

    // Between runs the pointers rest at zero and nothing is pending.
    a_idle_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_i == '0 && r_j == '0 && !r_pvalid)
        else $error("walk state left over while idle");

    // The finishing step always presents a last item.
    a_finish_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK && can_emit && walk_done |=> o_valid && o_result_last)
        else $error("run finished without a last result");

    // An empty item is only ever a last item.
    a_empty_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_empty |-> o_result_last)
        else $error("empty result not marked last");

    // A run clears both lists.
    a_run_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state == ST_WALK) |-> r_cnt_a == '0 && r_cnt_b == '0)
        else $error("lists not cleared after run");

endmodule

// ===== tb/tb_sorted_list_set_operations_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the sorted-list set operations unit
// Loads pairs of lists, fires run items under every set operation and checks
// each streamed element, its empty flag and its last flag against a
// behavioural walk of the same lists. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_sorted_list_set_operations_unit;

    import slso_pkg::*;

    localparam int DEPTH          = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS   = 250;
    // a run walks at most 2 * DEPTH comparison steps before it finishes
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int VAL_MIN        = -2147483647 - 1;
    localparam int VAL_MAX        = 2147483647;

    // the fourth mode code has no package name; the block ignores it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } t_list_item;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     empty;
        logic                     last;
    } t_set_element;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_mode         = MODE_LOAD_A;
    logic signed [DATA_W-1:0] i_value        = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_result_empty;
    logic                     o_result_last;
    logic                     i_cfg_valid    = 1'b0;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_set_op   = OP_MERGE;

    sorted_list_set_operations_unit #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_result_empty (o_result_empty),
        .o_result_last  (o_result_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_set_op   (i_cfg_set_op)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Shadow copy of the two lists, their fill counts and the set operation
    // -----------------------------------------------------------------------
    logic signed [DATA_W-1:0] shadow_a [DEPTH];
    logic signed [DATA_W-1:0] shadow_b [DEPTH];
    int                       fill_a = 0;
    int                       fill_b = 0;
    t_set_op                  shadow_op = OP_MERGE;

    t_list_item   items_to_send [$];   // filled by the sequencer, drained by the driver
    t_set_element due_elements [$];    // elements still awaited on the result channel

    int  items_queued   = 0;
    int  items_taken    = 0;
    int  counted_items  = 0;
    int  mismatches     = 0;
    bit  idle_on        = 1'b0;

    // Apply one accepted transfer to the shadow lists; a run walks both lists
    // and queues the elements it should stream out, then clears the lists.
    function automatic void apply_list_item(input logic [1:0] mode,
                                            input logic signed [DATA_W-1:0] value);
        logic signed [DATA_W-1:0] walk_out [$];
        logic signed [DATA_W-1:0] head_a;
        logic signed [DATA_W-1:0] head_b;
        t_set_element             elem;
        int                       ia;
        int                       ib;
        ia = 0;
        ib = 0;
        case (mode)
            MODE_LOAD_A: begin
                if (fill_a < DEPTH) begin
                    shadow_a[fill_a] = value;
                    fill_a++;
                end
            end
            MODE_LOAD_B: begin
                if (fill_b < DEPTH) begin
                    shadow_b[fill_b] = value;
                    fill_b++;
                end
            end
            MODE_RUN: begin
                while (ia < fill_a && ib < fill_b) begin
                    head_a = shadow_a[ia];
                    head_b = shadow_b[ib];
                    case (shadow_op)
                        OP_MERGE: begin
                            // equal heads: B goes first
                            if (head_a < head_b) begin
                                walk_out.push_back(head_a);
                                ia++;
                            end else begin
                                walk_out.push_back(head_b);
                                ib++;
                            end
                        end
                        OP_UNION: begin
                            if (head_a < head_b) begin
                                walk_out.push_back(head_a);
                                ia++;
                            end else if (head_b < head_a) begin
                                walk_out.push_back(head_b);
                                ib++;
                            end else begin
                                walk_out.push_back(head_b);
                                ia++;
                                ib++;
                            end
                        end
                        OP_INTERSECT: begin
                            // equal heads: emit A, advance A only
                            if (head_a < head_b) begin
                                ia++;
                            end else if (head_b < head_a) begin
                                ib++;
                            end else begin
                                walk_out.push_back(head_a);
                                ia++;
                            end
                        end
                        default: begin
                            if (head_a < head_b) begin
                                walk_out.push_back(head_a);
                                ia++;
                            end else if (head_b < head_a) begin
                                ib++;
                            end else begin
                                ia++;
                                ib++;
                            end
                        end
                    endcase
                end
                // flush the tails that the operation keeps
                if (shadow_op != OP_INTERSECT) begin
                    while (ia < fill_a) begin
                        walk_out.push_back(shadow_a[ia]);
                        ia++;
                    end
                end
                if (shadow_op == OP_MERGE || shadow_op == OP_UNION) begin
                    while (ib < fill_b) begin
                        walk_out.push_back(shadow_b[ib]);
                        ib++;
                    end
                end
                if (walk_out.size() == 0) begin
                    elem.value = '0;
                    elem.empty = 1'b1;
                    elem.last  = 1'b1;
                    due_elements.push_back(elem);
                end else begin
                    foreach (walk_out[n]) begin
                        elem.value = walk_out[n];
                        elem.empty = 1'b0;
                        elem.last  = (n == walk_out.size() - 1);
                        due_elements.push_back(elem);
                    end
                end
                fill_a = 0;
                fill_b = 0;
            end
            default: ;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Driver: present the next item once the previous transfer is done
    // -----------------------------------------------------------------------
    int         send_gap = 0;
    t_list_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_list_item(i_mode, i_value);
                items_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    // hold off for the rest of the idle burst
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    next_item = items_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_mode  <= next_item.mode;
                    i_value <= next_item.value;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: check every result transfer, stall the result side in bursts
    // -----------------------------------------------------------------------
    int           stall_left = 0;
    t_set_element awaited;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_elements.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: value %0d empty %0b last %0b",
                             $time, o_result_value, o_result_empty, o_result_last);
                end else begin
                    awaited = due_elements.pop_front();
                    if (o_result_value !== awaited.value) begin
                        mismatches++;
                        $display("%0t: result_value expected %0d actual %0d",
                                 $time, awaited.value, o_result_value);
                    end
                    if (o_result_empty !== awaited.empty) begin
                        mismatches++;
                        $display("%0t: result_empty expected %0b actual %0b",
                                 $time, awaited.empty, o_result_empty);
                    end
                    if (o_result_last !== awaited.last) begin
                        mismatches++;
                        $display("%0t: result_last expected %0b actual %0b",
                                 $time, awaited.last, o_result_last);
                    end
                end
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                // start a burst of stalled cycles
                i_stall    <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run when no transfer happens for too long
    // -----------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sorted_list_set_operations_unit verification failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    task automatic push_item(input logic [1:0] mode, input int value);
        t_list_item it;
        it.mode  = mode;
        it.value = value;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // Wait until every item has been taken and every element has come out,
    // then let a run that might still be winding down finish.
    task automatic settle();
        while (items_taken != items_queued || due_elements.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write set_op through the configuration channel; only call while idle.
    task automatic write_set_op(input t_set_op op);
        @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_cfg_set_op <= op;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_op = op;
    endtask

    // Interleave the loads of both lists at random, keeping each list's own order,
    // with the odd ignored item mixed in if add_noise is set, and close with a run item.
    task automatic queue_lists_and_run(input int a_vals[$], input int b_vals[$],
                                       input bit add_noise);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < a_vals.size() || ib < b_vals.size()) begin
            if (add_noise && $urandom_range(0, 19) == 0)
                push_item(MODE_UNUSED, $urandom);
            if (ib >= b_vals.size() || (ia < a_vals.size() && $urandom_range(0, 1) == 0)) begin
                push_item(MODE_LOAD_A, a_vals[ia]);
                // loads beyond a full list are dropped and not counted
                if (ia < DEPTH)
                    counted_items++;
                ia++;
            end else begin
                push_item(MODE_LOAD_B, b_vals[ib]);
                if (ib < DEPTH)
                    counted_items++;
                ib++;
            end
        end
        push_item(MODE_RUN, $urandom);
        counted_items++;
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, DEPTH);
        return $urandom_range(0, 5);
    endfunction

    // One random pair of lists and a run. Most pairs are ascending and drawn
    // from a narrow window so that equal heads turn up often.
    task automatic queue_random_run();
        int a_vals[$];
        int b_vals[$];
        int len_a;
        int len_b;
        int shape;
        int lo;
        int span;
        shape = $urandom_range(0, 11);
        len_a = pick_length();
        len_b = pick_length();
        if (shape == 0) begin
            // fill list A to DEPTH or beyond, and sometimes overfill list B
            len_a = DEPTH + $urandom_range(0, 4);
            len_b = $urandom_range(0, 1) ? DEPTH + $urandom_range(1, 4) : len_b;
        end
        span = ($urandom_range(0, 2) == 0) ? 3 : 24;
        lo   = $urandom;
        if (shape == 2)
            lo = VAL_MIN;
        else if (shape == 3)
            lo = VAL_MAX - span;
        if (lo > VAL_MAX - span)
            lo = VAL_MAX - span;
        repeat (len_a) begin
            if (shape == 1)
                a_vals.push_back($urandom);
            else
                a_vals.push_back(lo + $urandom_range(0, span));
        end
        repeat (len_b) begin
            if (shape == 1)
                b_vals.push_back($urandom);
            else
                b_vals.push_back(lo + $urandom_range(0, span));
        end
        if (shape == 4) begin
            // unsorted lists are walked just the same
            a_vals.shuffle();
            b_vals.shuffle();
        end else begin
            a_vals.sort();
            b_vals.sort();
        end
        queue_lists_and_run(a_vals, b_vals, 1'b1);
    endtask

    initial begin
        int      a_vals[$];
        int      b_vals[$];
        int      phase;
        t_set_op op;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the same pair under each operation, with the value
        // extremes and equal heads between and within the lists.
        for (int k = 0; k < 4; k++) begin
            op = t_set_op'(k);
            write_set_op(op);
            a_vals = '{VAL_MIN, -1, -1};
            b_vals = '{-1, VAL_MAX};
            queue_lists_and_run(a_vals, b_vals, 1'b0);
            if (op == OP_DIFF) begin
                // ignored mode, then a run on empty lists gives the empty flag
                push_item(MODE_UNUSED, VAL_MAX);
                push_item(MODE_RUN, VAL_MIN);
            end
            settle();
        end

        // Random phases: each one sets the operation while idle, then queues
        // several load-and-run sequences. Drop idling near the end.
        counted_items = 0;
        phase         = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (phase < 4)
                op = t_set_op'(3 - phase);
            else
                op = t_set_op'($urandom_range(0, 3));
            write_set_op(op);
            idle_on = (counted_items < RANDOM_ITEMS - 40) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 5)) queue_random_run();
            settle();
            phase++;
        end

        if (mismatches == 0) begin
            $display("sorted_list_set_operations_unit verification clean");
        end else begin
            $display("sorted_list_set_operations_unit verification failed");
        end
        $finish;
    end

endmodule
